[design/indexed_shift_list_unit_assert.svh]
// ----------------------------------------------------------------------------
// Indexed shift list assertion macros
// Shared property forms for the list unit checks.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SHIFT_LIST_UNIT_ASSERT_SVH
`define INDEXED_SHIFT_LIST_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define ISL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("indexed shift list: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define ISL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed shift list: next-cycle check failed");

`endif

[design/isl_pkg.sv]
// ----------------------------------------------------------------------------
// Indexed shift list package
// Sizes, operation and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package isl_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // length register and the width used for index compares
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int S_TDATA_W = ((POS_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + STATUS_W + COUNT_W + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] OP_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] OP_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] OP_GET    = 3'd2;
    localparam logic [KIND_W-1:0] OP_SET    = 3'd3;
    localparam logic [KIND_W-1:0] OP_REMOVE = 3'd4;
    localparam logic [KIND_W-1:0] OP_CLEAR  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // what every cell does in a cycle
    localparam logic [1:0] MODE_HOLD       = 2'd0;
    localparam logic [1:0] MODE_WRITE      = 2'd1;
    localparam logic [1:0] MODE_SHIFT_UP   = 2'd2;
    localparam logic [1:0] MODE_SHIFT_DOWN = 2'd3;

    typedef struct packed {
        logic [1:0]             mode;
        logic [CMP_W-1:0]       pos;
        logic [VALUE_WIDTH-1:0] value;
    } t_cell_ctrl;

endpackage

[design/isl_cell.sv]
// ----------------------------------------------------------------------------
// Indexed shift list cell
// Holds one entry; writes, or takes a neighbour's entry on insert and remove.
// ----------------------------------------------------------------------------
module isl_cell (
    input  logic                               i_clk,
    input  isl_pkg::t_cell_ctrl                i_ctrl,
    input  logic [isl_pkg::CMP_W-1:0]          i_index,
    input  logic [isl_pkg::VALUE_WIDTH-1:0]    i_lower,
    input  logic [isl_pkg::VALUE_WIDTH-1:0]    i_upper,
    output logic [isl_pkg::VALUE_WIDTH-1:0]    o_entry,
    output logic [isl_pkg::VALUE_WIDTH-1:0]    o_tap
);

    logic [isl_pkg::VALUE_WIDTH-1:0] r_entry;
    logic [isl_pkg::VALUE_WIDTH-1:0] n_entry;
    logic                            w_hit;
    logic                            w_above;

    assign w_hit   = (i_index == i_ctrl.pos);
    assign w_above = (i_index > i_ctrl.pos);

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctrl.mode)
            isl_pkg::MODE_HOLD: begin
                n_entry = r_entry;
            end
            isl_pkg::MODE_WRITE: begin
                if (w_hit) begin
                    n_entry = i_ctrl.value;
                end
            end
            isl_pkg::MODE_SHIFT_UP: begin
                // open a gap at the insert point
                if (w_hit) begin
                    n_entry = i_ctrl.value;
                end else if (w_above) begin
                    n_entry = i_lower;
                end
            end
            isl_pkg::MODE_SHIFT_DOWN: begin
                // close the gap left by the removed entry
                if (w_hit || w_above) begin
                    n_entry = i_upper;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_tap   = w_hit ? r_entry : '0;

endmodule

[design/indexed_shift_list_unit.sv]
// ----------------------------------------------------------------------------
// Indexed shift list unit
// Fixed-capacity ordered list held in a row of cells with one result each.
// ----------------------------------------------------------------------------
// Results: each transaction's result is registered in the output register.
// Throughput: one transaction per cycle while the output side takes results;
//   every cell updates in the same cycle, so insert and remove shift at once.
// Reset: clears the list length and the output valid; entries are not
//   cleared and are never read before they are written.
module indexed_shift_list_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [6:0] position, [38:7] item_value, [39] zero
    input  logic [isl_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [2:0] kind
    input  logic [isl_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] read_value, [33:32] status, [40:34] count, [47:41] zero
    output logic [isl_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int DEPTH = isl_pkg::DEPTH;
    localparam int VW    = isl_pkg::VALUE_WIDTH;
    localparam int CNT_W = isl_pkg::CNT_W;
    localparam int CMP_W = isl_pkg::CMP_W;
    localparam int POS_W = isl_pkg::POS_W;
    localparam int DW    = isl_pkg::DATA_W;
    localparam int SW    = isl_pkg::STATUS_W;
    localparam int CW    = isl_pkg::COUNT_W;
    localparam int MPAD  = isl_pkg::M_TDATA_W - DW - SW - CW;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_m_tvalid;
    logic [DW-1:0]      r_read_value;
    logic [SW-1:0]      r_status;
    logic [CW-1:0]      r_count_out;

    logic               w_accept;
    logic [isl_pkg::KIND_W-1:0] w_kind;
    logic [CMP_W-1:0]   w_pos;
    logic [CMP_W-1:0]   w_len;
    logic [VW-1:0]      w_value;
    logic               w_full;
    logic               w_in_range;
    logic               w_ins_range;
    logic [VW-1:0]      w_tap_or;
    logic [DW-1:0]      w_read_value;
    logic [SW-1:0]      w_status;
    isl_pkg::t_cell_ctrl w_ctrl;

    logic [VW-1:0]      w_entry [DEPTH];
    logic [VW-1:0]      w_tap   [DEPTH];

    assign s_axis_tready = !r_m_tvalid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_kind  = s_axis_tuser;
    assign w_pos   = CMP_W'(s_axis_tdata[POS_W-1:0]);
    assign w_value = VW'(s_axis_tdata[POS_W +: DW]);
    assign w_len   = CMP_W'(r_count);

    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_in_range  = (w_pos < w_len);
    assign w_ins_range = (w_pos <= w_len);

    // read port: the addressed cell drives its tap, all others drive zero
    always_comb begin
        w_tap_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_tap_or = w_tap_or | w_tap[k];
        end
    end

    always_comb begin
        w_ctrl.mode  = isl_pkg::MODE_HOLD;
        w_ctrl.pos   = w_pos;
        w_ctrl.value = w_value;
        w_status     = isl_pkg::ST_OK;
        w_read_value = '0;
        n_count      = r_count;
        unique case (w_kind)
            isl_pkg::OP_APPEND: begin
                w_ctrl.pos = w_len;
                if (w_full) begin
                    w_status = isl_pkg::ST_FULL;
                end else begin
                    w_ctrl.mode = isl_pkg::MODE_WRITE;
                    n_count     = r_count + CNT_W'(1);
                end
            end
            isl_pkg::OP_INSERT: begin
                priority if (!w_ins_range) begin
                    w_status = isl_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_status = isl_pkg::ST_FULL;
                end else begin
                    w_ctrl.mode = isl_pkg::MODE_SHIFT_UP;
                    n_count     = r_count + CNT_W'(1);
                end
            end
            isl_pkg::OP_GET: begin
                if (!w_in_range) begin
                    w_status = isl_pkg::ST_RANGE;
                end else begin
                    w_read_value = DW'(w_tap_or);
                end
            end
            isl_pkg::OP_SET: begin
                if (!w_in_range) begin
                    w_status = isl_pkg::ST_RANGE;
                end else begin
                    w_read_value = DW'(w_tap_or);
                    w_ctrl.mode  = isl_pkg::MODE_WRITE;
                end
            end
            isl_pkg::OP_REMOVE: begin
                if (!w_in_range) begin
                    w_status = isl_pkg::ST_RANGE;
                end else begin
                    w_read_value = DW'(w_tap_or);
                    w_ctrl.mode  = isl_pkg::MODE_SHIFT_DOWN;
                    n_count      = r_count - CNT_W'(1);
                end
            end
            isl_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        // hold every cell unless a transaction is taken
        if (!w_accept) begin
            w_ctrl.mode = isl_pkg::MODE_HOLD;
        end
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [VW-1:0] w_lower;
        logic [VW-1:0] w_upper;

        if (k == 0) begin : g_first
            assign w_lower = '0;
        end else begin : g_inner_lo
            assign w_lower = w_entry[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_inner_hi
            assign w_upper = w_entry[k+1];
        end

        isl_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_index (CMP_W'(k)),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_entry (w_entry[k]),
            .o_tap   (w_tap[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count    <= n_count;
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_value <= w_read_value;
            r_status     <= w_status;
            r_count_out  <= CW'(n_count);
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = {{MPAD{1'b0}}, r_count_out, r_status, r_read_value};

`include "indexed_shift_list_unit_assert.svh"

    `ISL_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `ISL_ASSERT_NEXT(a_append_grows, i_clk, i_rst_n,
        w_accept && (w_kind == isl_pkg::OP_APPEND) && !w_full,
        r_count == $past(r_count) + CNT_W'(1))
    `ISL_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n,
        w_accept && (w_kind == isl_pkg::OP_CLEAR), (r_count == '0) && r_m_tvalid)
    `ISL_ASSERT_IMP(a_full_count, i_clk, i_rst_n,
        r_m_tvalid && (r_status == isl_pkg::ST_FULL), r_count_out == CW'(DEPTH))
    `ISL_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n,
        r_m_tvalid && (r_status != isl_pkg::ST_OK), r_read_value == '0)

endmodule
